/* hdl/ffha_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
package ffha_pkg;

    // Width of a request rounded to 16-byte granules (65535 bytes -> 4096 granules).
    localparam int unsigned NEED_W = 13;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_QUERY   = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] request_bytes;
        logic [13:0] block_offset;
    } ffha_in_t;

    typedef struct packed {
        logic [13:0] result_offset;
        logic [13:0] block_bytes;
        logic        alloc_failed;
        logic        bad_offset;
        logic [14:0] bytes_in_use;
        logic [14:0] peak_in_use;
        logic [31:0] grant_count;
        logic [31:0] release_count;
        logic [31:0] exhaust_count;
    } ffha_out_t;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_DISP,
        ST_A_RD, ST_A_CHK, ST_A_SPL,
        ST_R_LOC, ST_R_CHK,
        ST_M_RDP, ST_M_CHKP, ST_M_NXT, ST_M_RDN, ST_M_CHKN, ST_M_WRP,
        ST_Q_LOC, ST_Q_CHK,
        ST_FIN
    } ffha_state_t;

    typedef enum logic [4:0] {
        DP_IDLE, DP_CLR, DP_LATCH,
        DP_A_RD, DP_A_CHK, DP_A_SPL, DP_A_FAIL,
        DP_L_RD, DP_R_BAD, DP_R_CHK,
        DP_M_RDP, DP_M_CHKP, DP_M_NXT, DP_M_RDN, DP_M_CHKN, DP_M_WRP,
        DP_Q_CHK, DP_EMIT
    } ffha_op_t;

    typedef struct packed {
        ffha_op_t op;
    } ffha_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       clr_last;
        logic       ptr_end;
        logic       off_null;
        logic       loc_ok;
        logic       hit;
        logic       split;
        logic       hdr;
        logic       blk_free;
        logic       nxt_in;
        logic       out_free;
    } ffha_sts_t;

endpackage

/* hdl/first_fit_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator: joins the controller and the datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_data (ffha_in_t: func, request_bytes, block_offset)
//  m_      | out       | m_valid / m_ready  | m_data (ffha_out_t: offsets, flags, statistics)
//
// After reset the block table is cleared in one pass over its ARENA_BYTES/16 entries (1024 at the
// default size), during which s_ready stays low.
// One transaction is worked on at a time. An allocate reads and checks each block on the first-fit
// walk and splits the block that it takes when the rest is large enough; a release checks the block
// and then merges free neighbours in a walk over the whole list; a query reads the block's entry.
// A finished result waits in the output register; the next transaction is taken meanwhile
// and stalls only at its end if m_ready is still low.
module first_fit_heap_allocator_unit #(
    parameter int unsigned ARENA_BYTES = 16384
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffha_pkg::ffha_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffha_pkg::ffha_out_t m_data
);
    import ffha_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    ffha_cmd_t cmd;
    ffha_sts_t sts;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the block table, the walk pointers and the statistics.
    ffha_dp #(
        .ARENA_BYTES (ARENA_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

/* hdl/ffha_ctrl.sv */
// Controller state machine of the allocator: sequences clear, walk, merge and result steps.
// Depends on ffha_pkg.
module ffha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffha_pkg::ffha_sts_t sts,
    output ffha_pkg::ffha_cmd_t cmd
);
    import ffha_pkg::*;

    ffha_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:    if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (s_valid) state_next = ST_DISP;
            ST_DISP: begin
                case (sts.func)
                    FN_ALLOC:   state_next = ST_A_RD;
                    FN_RELEASE: state_next = ST_R_LOC;
                    FN_QUERY:   state_next = ST_Q_LOC;
                    default:    state_next = ST_FIN;
                endcase
            end
            ST_A_RD:   state_next = sts.ptr_end ? ST_FIN : ST_A_CHK;
            ST_A_CHK: begin
                if (sts.hit) state_next = sts.split ? ST_A_SPL : ST_FIN;
                else state_next = ST_A_RD;
            end
            ST_A_SPL:  state_next = ST_FIN;
            ST_R_LOC: begin
                if (sts.off_null || !sts.loc_ok) state_next = ST_FIN;
                else state_next = ST_R_CHK;
            end
            ST_R_CHK:  state_next = sts.hdr ? ST_M_RDP : ST_FIN;
            ST_M_RDP:  state_next = sts.ptr_end ? ST_FIN : ST_M_CHKP;
            ST_M_CHKP: state_next = sts.blk_free ? ST_M_NXT : ST_M_RDP;
            ST_M_NXT:  state_next = sts.nxt_in ? ST_M_RDN : ST_M_RDP;
            ST_M_RDN:  state_next = ST_M_CHKN;
            ST_M_CHKN: state_next = (sts.hdr && sts.blk_free) ? ST_M_WRP : ST_M_RDP;
            ST_M_WRP:  state_next = ST_M_NXT;
            ST_Q_LOC: begin
                if (sts.off_null || !sts.loc_ok) state_next = ST_FIN;
                else state_next = ST_Q_CHK;
            end
            ST_Q_CHK:  state_next = ST_FIN;
            ST_FIN:    if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLR;
        endcase
    end

    always_comb begin
        cmd.op  = DP_IDLE;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLR:    cmd.op = DP_CLR;
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = DP_LATCH;
            end
            ST_A_RD:   cmd.op = sts.ptr_end ? DP_A_FAIL : DP_A_RD;
            ST_A_CHK:  cmd.op = DP_A_CHK;
            ST_A_SPL:  cmd.op = DP_A_SPL;
            ST_R_LOC: begin
                if (!sts.off_null) cmd.op = sts.loc_ok ? DP_L_RD : DP_R_BAD;
            end
            ST_R_CHK:  cmd.op = DP_R_CHK;
            ST_M_RDP:  cmd.op = sts.ptr_end ? DP_IDLE : DP_M_RDP;
            ST_M_CHKP: cmd.op = DP_M_CHKP;
            ST_M_NXT:  cmd.op = DP_M_NXT;
            ST_M_RDN:  cmd.op = DP_M_RDN;
            ST_M_CHKN: cmd.op = DP_M_CHKN;
            ST_M_WRP:  cmd.op = DP_M_WRP;
            ST_Q_LOC: begin
                if (!sts.off_null && sts.loc_ok) cmd.op = DP_L_RD;
            end
            ST_Q_CHK:  cmd.op = DP_Q_CHK;
            ST_FIN:    if (sts.out_free) cmd.op = DP_EMIT;
            default:   cmd.op = DP_IDLE;
        endcase
    end

endmodule

/* hdl/ffha_dp.sv */
// Datapath of the allocator: block table memory, walk pointers, statistics and result register.
// Depends on ffha_pkg; driven by ffha_ctrl through ffha_cmd_t.
module ffha_dp #(
    parameter int unsigned ARENA_BYTES = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffha_pkg::ffha_in_t   s_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output ffha_pkg::ffha_out_t  m_data,
    input  ffha_pkg::ffha_cmd_t  cmd,
    output ffha_pkg::ffha_sts_t  sts
);
    import ffha_pkg::*;

    localparam int unsigned G  = ARENA_BYTES / 16;
    localparam int unsigned GW = $clog2(G);
    localparam int unsigned PW = GW + 1;
    localparam int unsigned UW = $clog2(ARENA_BYTES) + 1;
    localparam int unsigned EW = GW + 2;

    // Entry: header bit, free bit, payload size in granules.
    logic [EW-1:0] mem [G];
    logic [EW-1:0] rd_q;
    logic [GW-1:0] rd_addr;
    logic          rd_en;
    logic [GW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;

    logic [GW-1:0]     clr_reg, clr_next;
    logic [1:0]        func_reg, func_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [13:0]       off_reg, off_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [PW-1:0]     nxt_reg, nxt_next;
    logic [GW-1:0]     psize_reg, psize_next;
    logic [13:0]       roff_reg, roff_next;
    logic [13:0]       bytes_reg, bytes_next;
    logic              fail_reg, fail_next;
    logic              bad_reg, bad_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [UW-1:0]     peak_reg, peak_next;
    logic [31:0]       grant_reg, grant_next;
    logic [31:0]       rel_reg, rel_next;
    logic [31:0]       exh_reg, exh_next;
    logic              mv_reg, mv_next;
    ffha_out_t         out_reg, out_next;

    logic          rd_hdr, rd_free;
    logic [GW-1:0] rd_size;
    logic          hit, split;
    logic [GW-1:0] gsize;
    logic [UW-1:0] taken, used_add;
    logic [PW-1:0] ptr_after;
    logic [31:0]   idx_wide;
    logic          loc_ok;
    logic [GW-1:0] idx;

    assign rd_hdr  = rd_q[GW+1];
    assign rd_free = rd_q[GW];
    assign rd_size = rd_q[GW-1:0];
    assign hit     = rd_hdr && rd_free && (32'(rd_size) >= 32'(need_reg));
    assign split   = 32'(rd_size) >= 32'(need_reg) + 32'd2;
    assign gsize   = split ? GW'(need_reg) : rd_size;
    assign taken   = UW'((32'(rd_size) + 32'd1) << 4);
    assign used_add = UW'((32'(gsize) + 32'd1) << 4);
    assign ptr_after = PW'(32'(ptr_reg) + 32'd1 + 32'(rd_size));
    assign idx_wide = 32'(off_reg[13:4]) - 32'd1;
    assign loc_ok  = (off_reg[3:0] == 4'd0) && (off_reg[13:4] != 10'd0) && (idx_wide < 32'(G));
    assign idx     = GW'(idx_wide);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            used_reg  <= '0;
            peak_reg  <= '0;
            grant_reg <= '0;
            rel_reg   <= '0;
            exh_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            peak_reg  <= peak_next;
            grant_reg <= grant_next;
            rel_reg   <= rel_next;
            exh_reg   <= exh_next;
            mv_reg    <= mv_next;
        end
        func_reg  <= func_next;
        need_reg  <= need_next;
        off_reg   <= off_next;
        ptr_reg   <= ptr_next;
        nxt_reg   <= nxt_next;
        psize_reg <= psize_next;
        roff_reg  <= roff_next;
        bytes_reg <= bytes_next;
        fail_reg  <= fail_next;
        bad_reg   <= bad_next;
        out_reg   <= out_next;
    end

    always_comb begin
        clr_next   = clr_reg;
        func_next  = func_reg;
        need_next  = need_reg;
        off_next   = off_reg;
        ptr_next   = ptr_reg;
        nxt_next   = nxt_reg;
        psize_next = psize_reg;
        roff_next  = roff_reg;
        bytes_next = bytes_reg;
        fail_next  = fail_reg;
        bad_next   = bad_reg;
        used_next  = used_reg;
        peak_next  = peak_reg;
        grant_next = grant_reg;
        rel_next   = rel_reg;
        exh_next   = exh_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_ready;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[GW-1:0];
        wr_en      = 1'b0;
        wr_addr    = ptr_reg[GW-1:0];
        wr_data    = '0;
        case (cmd.op)
            DP_CLR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = (clr_reg == '0) ? {2'b11, GW'(G - 1)} : '0;
                clr_next = clr_reg + 1'b1;
            end
            DP_LATCH: begin
                func_next  = s_data.func;
                need_next  = (s_data.request_bytes == 16'd0) ? NEED_W'(1) :
                             NEED_W'((17'(s_data.request_bytes) + 17'd15) >> 4);
                off_next   = s_data.block_offset;
                ptr_next   = '0;
                roff_next  = '0;
                bytes_next = '0;
                fail_next  = 1'b0;
                bad_next   = 1'b0;
            end
            DP_A_RD: rd_en = 1'b1;
            DP_A_CHK: begin
                if (hit) begin
                    wr_en      = 1'b1;
                    wr_data    = {2'b10, gsize};
                    psize_next = rd_size;
                    grant_next = grant_reg + 32'd1;
                    used_next  = used_reg + used_add;
                    if (used_reg + used_add > peak_reg) peak_next = used_reg + used_add;
                    roff_next  = 14'((32'(ptr_reg) + 32'd1) << 4);
                    bytes_next = 14'(32'(gsize) << 4);
                end else begin
                    ptr_next = ptr_after;
                end
            end
            DP_A_SPL: begin
                wr_en   = 1'b1;
                wr_addr = GW'(32'(ptr_reg) + 32'd1 + 32'(need_reg));
                wr_data = {2'b11, GW'(32'(psize_reg) - 32'(need_reg) - 32'd1)};
            end
            DP_A_FAIL: begin
                fail_next = 1'b1;
                exh_next  = exh_reg + 32'd1;
            end
            DP_L_RD: begin
                rd_en    = 1'b1;
                rd_addr  = idx;
                ptr_next = PW'(idx);
            end
            DP_R_BAD: bad_next = 1'b1;
            DP_R_CHK: begin
                if (!rd_hdr) begin
                    bad_next = 1'b1;
                end else begin
                    if (!rd_free) begin
                        rel_next  = rel_reg + 32'd1;
                        used_next = (used_reg >= taken) ? used_reg - taken : '0;
                    end
                    wr_en    = 1'b1;
                    wr_data  = {2'b11, rd_size};
                    ptr_next = '0;
                end
            end
            DP_M_RDP: rd_en = 1'b1;
            DP_M_CHKP: begin
                psize_next = rd_size;
                nxt_next   = ptr_after;
                if (!rd_free) ptr_next = ptr_after;
            end
            DP_M_NXT: if (32'(nxt_reg) >= 32'(G)) ptr_next = nxt_reg;
            DP_M_RDN: begin
                rd_en   = 1'b1;
                rd_addr = nxt_reg[GW-1:0];
            end
            DP_M_CHKN: begin
                if (rd_hdr && rd_free) begin
                    psize_next = GW'(32'(psize_reg) + 32'd1 + 32'(rd_size));
                    wr_en      = 1'b1;
                    wr_addr    = nxt_reg[GW-1:0];
                    wr_data    = '0;
                end else begin
                    ptr_next = nxt_reg;
                end
            end
            DP_M_WRP: begin
                wr_en    = 1'b1;
                wr_data  = {2'b11, psize_reg};
                nxt_next = PW'(32'(ptr_reg) + 32'd1 + 32'(psize_reg));
            end
            DP_Q_CHK: if (rd_hdr) bytes_next = 14'(32'(rd_size) << 4);
            DP_EMIT: begin
                mv_next = 1'b1;
                out_next.result_offset = roff_reg;
                out_next.block_bytes   = bytes_reg;
                out_next.alloc_failed  = fail_reg;
                out_next.bad_offset    = bad_reg;
                out_next.bytes_in_use  = 15'(used_reg);
                out_next.peak_in_use   = 15'(peak_reg);
                out_next.grant_count   = grant_reg;
                out_next.release_count = rel_reg;
                out_next.exhaust_count = exh_reg;
            end
            default: ;
        endcase
    end

    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    always_comb begin
        sts.func     = func_reg;
        sts.clr_last = (clr_reg == GW'(G - 1));
        sts.ptr_end  = 32'(ptr_reg) >= 32'(G);
        sts.off_null = (off_reg == 14'd0);
        sts.loc_ok   = loc_ok;
        sts.hit      = hit;
        sts.split    = split;
        sts.hdr      = rd_hdr;
        sts.blk_free = rd_free;
        sts.nxt_in   = 32'(nxt_reg) < 32'(G);
        sts.out_free = !mv_reg || m_ready;
    end

endmodule

/* hdl/ffha_checker.sv */
// Port-level checker of the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_unit.
module ffha_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ffha_pkg::ffha_out_t m_data,
    input logic                m_valid,
    input logic                m_ready
);
    import ffha_pkg::*;

    // The table clearing pass keeps the input closed right after reset.
    a_clear_closed: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input open during table clearing");

    // A transaction on offer stays on offer until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("offered transaction withdrawn");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.peak_in_use >= m_data.bytes_in_use)
        else $error("peak below bytes in use");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.alloc_failed |->
        m_data.result_offset == 14'd0 && m_data.block_bytes == 14'd0 && !m_data.bad_offset)
        else $error("failed allocate carries a grant");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
